// ===== design/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants for the serial frame checker
// Frame marker bytes, the CRC-16 polynomial and its bytewise update, the
// status codes, and the structs passed between the checker's stages.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  // Frame marker bytes
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] VER_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] EOT_BYTE = 8'h04;

  // Reflected CRC-16, no final xor
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Frame positions
  localparam int unsigned POS_W    = 9;
  localparam int unsigned HDR_DEPTH = 10;
  localparam int unsigned HDR_IDX_W = 4;
  localparam logic [POS_W-1:0] POS_SOH    = 9'd0;
  localparam logic [POS_W-1:0] POS_VER    = 9'd1;
  localparam logic [POS_W-1:0] POS_HDR_LO = 9'd2;
  localparam logic [POS_W-1:0] POS_LEN    = 9'd6;
  localparam logic [POS_W-1:0] POS_STX    = 9'd7;
  localparam logic [POS_W-1:0] POS_HDR_HI = 9'd11;
  localparam logic [POS_W-1:0] OFS_ETX    = 9'd8;
  localparam logic [POS_W-1:0] OFS_CRC_LO = 9'd9;
  localparam logic [POS_W-1:0] OFS_CRC_HI = 9'd10;
  localparam logic [POS_W-1:0] OFS_EOT    = 9'd11;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FRAMING   = 2'd1,
    ST_VERSION   = 2'd2,
    ST_CRC       = 2'd3
  } status_t;

  // One request from the input channel
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [15:0] dest_address;
    logic [15:0] source_address;
    logic [7:0]  payload_length;
    logic [7:0]  command;
    logic [7:0]  command_version;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [15:0] computed_crc;
  } result_t;

  // Fold one byte into the CRC, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    logic [7:0]  d;
    logic        fb;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ d[0];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== design/fsc_in_stage.sv =====
// ----------------------------------------------------------------------------
// fsc_in_stage: input register
// Captures one request per cycle while the frame engine keeps consuming,
// and holds it until the frame engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fsc_pkg::item_t in_item,
  input  wire logic          take,
  output logic               item_valid,
  output fsc_pkg::item_t     item
);
  import fsc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Free the slot when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== design/fsc_engine.sv =====
// ----------------------------------------------------------------------------
// fsc_engine: frame state and checks
// Tracks the byte position, error flags, running CRC and header bytes of
// the open frame, and forms the result on the EOT position.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           item_valid,
  input  wire fsc_pkg::item_t item,
  input  wire logic           take,
  output logic                has_result,
  output fsc_pkg::result_t    result
);
  import fsc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       len_r, len_nxt;
  logic             fe_r, fe_nxt;
  logic             ve_r, ve_nxt;
  logic             ce_r, ce_nxt;
  logic [7:0]       hdr_r [HDR_DEPTH];

  logic             start;
  logic             active;
  logic [7:0]       b;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] len_ext;
  logic [15:0]      crc_base;
  logic             is_end;
  logic             hdr_we;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [POS_W-1:0] hdr_ofs;
  logic [7:0]       last_hdr;
  status_t          st;

  assign start  = item.frame_start;
  assign b      = item.rx_byte;
  assign active = item_valid && (start || in_frame_r);
  assign pos    = start ? POS_SOH : pos_r;

  // Evaluate checks and next state for the held byte
  always_comb begin
    fe_nxt   = start ? 1'b0 : fe_r;
    ve_nxt   = start ? 1'b0 : ve_r;
    ce_nxt   = start ? 1'b0 : ce_r;
    len_nxt  = start ? 8'd0 : len_r;
    crc_base = start ? CRC_INIT : crc_r;

    if (pos == POS_SOH && b != SOH_BYTE) fe_nxt = 1'b1;
    if (pos == POS_VER && b != VER_BYTE) ve_nxt = 1'b1;
    if (pos == POS_STX && b != STX_BYTE) fe_nxt = 1'b1;
    if (pos == POS_LEN) len_nxt = b;

    len_ext = {1'b0, len_nxt};

    // CRC covers the header and payload through ETX
    if (pos < POS_STX || pos <= len_ext + OFS_ETX) begin
      crc_nxt = crc_update(crc_base, b);
    end else begin
      crc_nxt = crc_base;
    end

    if (pos == len_ext + OFS_ETX && b != ETX_BYTE) fe_nxt = 1'b1;
    if (pos == len_ext + OFS_CRC_LO && b != crc_nxt[7:0]) ce_nxt = 1'b1;
    if (pos == len_ext + OFS_CRC_HI && b != crc_nxt[15:8]) ce_nxt = 1'b1;
    is_end = (pos == len_ext + OFS_EOT);
    if (is_end && b != EOT_BYTE) fe_nxt = 1'b1;

    if (is_end) begin
      in_frame_nxt = 1'b0;
      pos_nxt      = POS_SOH;
    end else begin
      in_frame_nxt = 1'b1;
      pos_nxt      = pos + 9'd1;
    end
  end

  // Header capture address
  assign hdr_we  = (pos >= POS_HDR_LO) && (pos <= POS_HDR_HI);
  assign hdr_ofs = pos - POS_HDR_LO;
  assign hdr_idx = hdr_ofs[HDR_IDX_W-1:0];

  // Advance frame state on each consumed in-frame byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_SOH;
      in_frame_r <= 1'b0;
      crc_r      <= CRC_INIT;
      len_r      <= 8'd0;
      fe_r       <= 1'b0;
      ve_r       <= 1'b0;
      ce_r       <= 1'b0;
    end else if (take && active) begin
      pos_r      <= pos_nxt;
      in_frame_r <= in_frame_nxt;
      crc_r      <= crc_nxt;
      len_r      <= len_nxt;
      fe_r       <= fe_nxt;
      ve_r       <= ve_nxt;
      ce_r       <= ce_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active && hdr_we) begin
      hdr_r[hdr_idx] <= b;
    end
  end

  // Byte 11 may be the EOT byte itself when the payload is empty
  assign last_hdr = (pos == POS_HDR_HI) ? b : hdr_r[9];

  always_comb begin
    if (fe_nxt) begin
      st = ST_FRAMING;
    end else if (ve_nxt) begin
      st = ST_VERSION;
    end else if (ce_nxt) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end
  end

  assign has_result = active && is_end;

  always_comb begin
    result.status          = st;
    result.dest_address    = {hdr_r[3], hdr_r[2]};
    result.source_address  = {hdr_r[1], hdr_r[0]};
    result.payload_length  = hdr_r[4];
    result.command         = hdr_r[6];
    result.command_version = hdr_r[7];
    result.param_first     = hdr_r[8];
    result.param_second    = last_hdr;
    result.computed_crc    = crc_nxt;
  end

endmodule

`default_nettype wire

// ===== design/fsc_out_stage.sv =====
// ----------------------------------------------------------------------------
// fsc_out_stage: result register
// Holds one finished result until the receiver takes it; accepts a new
// one in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire fsc_pkg::result_t res_in,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fsc_pkg::result_t      res_out
);
  import fsc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

// ===== design/serial_frame_checker_crc16_core.sv =====
// ----------------------------------------------------------------------------
// serial_frame_checker_crc16_core: request frame checker with CRC-16
// Checks framing, version and CRC of a serial request frame and reports
// one result per frame with its addresses, command and parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per request;
//   in_frame_start marks byte 0 and drops any partial frame. Bytes outside
//   a frame are consumed without effect.
//   Result channel (out_valid/out_ready) carries one result per frame,
//   produced by the EOT byte at position 11 + length.
//   Throughput: one byte per cycle while no result stalls. The bytewise
//   CRC update is a fixed eight-step network between the input register
//   and the result register, into which the EOT byte's result is loaded.
//   Stall: a result waits in the output register; the input register keeps
//   taking bytes until a second result has nowhere to go, then in_ready
//   drops until out_ready frees the output register.
//   Reset (rst_n low, synchronous) empties both registers and closes any
//   open frame; header bytes are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_checker_crc16_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_dest_address,
  output logic [15:0]      out_source_address,
  output logic [7:0]       out_payload_length,
  output logic [7:0]       out_command,
  output logic [7:0]       out_command_version,
  output logic [7:0]       out_param_first,
  output logic [7:0]       out_param_second,
  output logic [15:0]      out_computed_crc
);
  import fsc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    has_result;
  logic    can_load;
  result_t result;
  result_t res_out;

  assign in_item.rx_byte     = in_rx_byte;
  assign in_item.frame_start = in_frame_start;

  // Consume the held byte unless its result has no room
  assign take = item_valid && (!has_result || can_load);

  fsc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  fsc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .has_result (has_result),
    .result     (result)
  );

  fsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && has_result),
    .res_in    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign out_status          = res_out.status;
  assign out_dest_address    = res_out.dest_address;
  assign out_source_address  = res_out.source_address;
  assign out_payload_length  = res_out.payload_length;
  assign out_command         = res_out.command;
  assign out_command_version = res_out.command_version;
  assign out_param_first     = res_out.param_first;
  assign out_param_second    = res_out.param_second;
  assign out_computed_crc    = res_out.computed_crc;

endmodule

`default_nettype wire

// ===== design/fsc_checker.sv =====
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks for the frame checker
// Watches the top-level ports for handshake and result timing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_computed_crc
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_computed_crc))
    else $error("result changed while stalled");

  // Empty result register after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result follows an accepted byte through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind serial_frame_checker_crc16_core fsc_checker u_fsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_computed_crc (out_computed_crc)
);

`default_nettype wire
